// ===== design/tvm_pkg.sv =====
// ============================================================================
// tvm_pkg: shared types and constants of the tiny VM execute unit
// Instruction and result transfer formats, operation codes, register map.
// ============================================================================
`default_nettype none

package tvm_pkg;

  localparam int unsigned PC_W      = 16;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned DEF_MEM_WORDS = 256;

  // Word index of the program size register in the APB map.
  localparam logic REG_PROGRAM_SIZE = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 3'd0,
    KIND_ADD   = 3'd1,
    KIND_JNE   = 3'd2,
    KIND_PRINT = 3'd3,
    KIND_RET   = 3'd4
  } kind_e;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [PC_W-1:0]          current_pc;
    logic [IDX_W-1:0]         index_a;
    logic [IDX_W-1:0]         index_b;
    logic [IDX_W-1:0]         index_c;
    logic signed [WORD_W-1:0] immediate;
    logic [PC_W-1:0]          jump_target;
  } in_item_t;

  typedef struct packed {
    logic [PC_W-1:0]          next_pc;
    logic                     finished;
    logic                     print_valid;
    logic signed [WORD_W-1:0] print_value;
  } out_item_t;

endpackage

`default_nettype wire

// ===== design/tvm_dmem.sv =====
// ============================================================================
// tvm_dmem: data memory of the tiny VM execute unit
// One write port and two registered read ports; a read in the same cycle as a
// write to the same word returns the old contents.
// ============================================================================
`default_nettype none

module tvm_dmem #(
  parameter int unsigned WORDS = tvm_pkg::DEF_MEM_WORDS,
  parameter int unsigned AW    = $clog2(tvm_pkg::DEF_MEM_WORDS)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rd_en_i,
  input  wire logic [AW-1:0]                 rd_addr_a_i,
  input  wire logic [AW-1:0]                 rd_addr_b_i,
  output logic      [tvm_pkg::WORD_W-1:0]    rd_data_a_o,
  output logic      [tvm_pkg::WORD_W-1:0]    rd_data_b_o,
  input  wire logic                          wr_en_i,
  input  wire logic [AW-1:0]                 wr_addr_i,
  input  wire logic [tvm_pkg::WORD_W-1:0]    wr_data_i
);

  logic [tvm_pkg::WORD_W-1:0] mem_q [WORDS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_a_o <= mem_q[rd_addr_a_i];
      rd_data_b_o <= mem_q[rd_addr_b_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/tvm_cfg.sv =====
// ============================================================================
// tvm_cfg: APB register block of the tiny VM execute unit
// Holds the program size register.
// ============================================================================
`default_nettype none

module tvm_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tvm_pkg::APB_AW-1:0]    paddr,
  input  wire logic [tvm_pkg::APB_DW-1:0]    pwdata,
  output logic      [tvm_pkg::APB_DW-1:0]    prdata,
  output logic                               pready,
  output logic      [tvm_pkg::PC_W-1:0]      program_size_o
);

  logic [tvm_pkg::PC_W-1:0] program_size_q;
  logic                     hit;

  // Registers are word aligned; the low two address bits are ignored.
  assign hit    = (paddr[2] == tvm_pkg::REG_PROGRAM_SIZE);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      program_size_q <= '0;
    end else if (psel && penable && pwrite && hit) begin
      program_size_q <= pwdata[tvm_pkg::PC_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata[tvm_pkg::PC_W-1:0] = program_size_q;
    end
  end

  assign program_size_o = program_size_q;

endmodule

`default_nettype wire

// ===== design/tiny_vm_execute_unit_core.sv =====
// ============================================================================
// tiny_vm_execute_unit_core: execute stage of a five-operation virtual machine
// Runs decoded load, add, jump-if-not-equal, print and return instructions
// against an internal data memory and reports the next program counter.
// ============================================================================
// The unit retires one instruction per clock cycle and takes a new instruction
// in every cycle in which the result side keeps up. In the cycle of its
// transfer an instruction reads up to two data words from the synchronous
// memory; in the execute stage the registered read data is then combined
// (sum, compare or print) and written back, while the result goes into the
// output register. A word written by one instruction is forwarded to the
// instruction right behind it, so back-to-back dependent instructions run at
// full rate. After reset the data memory is cleared by a pass that writes one
// word per cycle over all MEM_WORDS words; the input channel stalls during that
// pass, while program_size can be written over APB at any time. Word indexes
// wrap modulo MEM_WORDS. Program_size should be written only while no
// instruction is in flight.
`default_nettype none

module tiny_vm_execute_unit_core #(
  parameter int unsigned MEM_WORDS = tvm_pkg::DEF_MEM_WORDS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Instruction channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire tvm_pkg::in_item_t             in_item_i,
  // Result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output tvm_pkg::out_item_t                 out_item_o,
  // APB configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tvm_pkg::APB_AW-1:0]    paddr,
  input  wire logic [tvm_pkg::APB_DW-1:0]    pwdata,
  output logic      [tvm_pkg::APB_DW-1:0]    prdata,
  output logic                               pready
);

  localparam int unsigned AW       = $clog2(MEM_WORDS);
  localparam int unsigned IDX_SPAN = 2 ** tvm_pkg::IDX_W;
  localparam int unsigned WW       = tvm_pkg::WORD_W;
  localparam int unsigned PW       = tvm_pkg::PC_W;

  typedef logic [AW-1:0] idx_tab_t [IDX_SPAN];

  // Maps every possible 8-bit word index to its memory address.
  function automatic idx_tab_t build_idx_tab();
    idx_tab_t tab;
    for (int i = 0; i < IDX_SPAN; i++) begin
      tab[i] = AW'(i % MEM_WORDS);
    end
    return tab;
  endfunction

  localparam idx_tab_t IdxTab = build_idx_tab();

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [PW-1:0] program_size;

  tvm_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .program_size_o (program_size)
  );

  // --------------------------------------------------------------------------
  // Handshake and clearing pass
  // --------------------------------------------------------------------------
  logic          clr_busy_q, clr_busy_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;
  logic          s1_valid_q, s1_valid_d;
  logic          out_valid_q, out_valid_d;
  logic          adv;
  logic          in_accept;

  // The execute stage moves on whenever the output register is free or its
  // result is being transferred in this cycle.
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = clr_busy_q || (s1_valid_q && !adv);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(MEM_WORDS - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Read stage: address the memory in the cycle of the input transfer
  // --------------------------------------------------------------------------
  logic [AW-1:0] rd_addr_a, rd_addr_b;
  logic [WW-1:0] rd_data_a, rd_data_b;

  // Add reads its two addends; every other operation reads index_a and index_b.
  always_comb begin
    if (in_item_i.kind == tvm_pkg::KIND_ADD) begin
      rd_addr_a = IdxTab[in_item_i.index_b];
      rd_addr_b = IdxTab[in_item_i.index_c];
    end else begin
      rd_addr_a = IdxTab[in_item_i.index_a];
      rd_addr_b = IdxTab[in_item_i.index_b];
    end
  end

  // --------------------------------------------------------------------------
  // Execute stage
  // --------------------------------------------------------------------------
  tvm_pkg::in_item_t s1_item_q;
  logic [AW-1:0]     s1_addr_a_q, s1_addr_b_q, s1_waddr_q;
  logic              fwd_valid_q, fwd_valid_d;
  logic [AW-1:0]     fwd_addr_q;
  logic [WW-1:0]     fwd_data_q;

  logic [WW-1:0]     op_a, op_b;
  logic              s1_wr;
  logic [WW-1:0]     s1_wdata;
  logic [PW:0]       next_full;
  logic              pvalid;
  logic [WW-1:0]     pvalue;
  logic              is_write;

  // A word written at the same edge at which the reading instruction entered
  // was missed by the memory read; take it from the forwarding register.
  assign op_a = (fwd_valid_q && fwd_addr_q == s1_addr_a_q) ? fwd_data_q : rd_data_a;
  assign op_b = (fwd_valid_q && fwd_addr_q == s1_addr_b_q) ? fwd_data_q : rd_data_b;

  always_comb begin
    next_full = {1'b0, s1_item_q.current_pc} + (PW + 1)'(1);
    pvalid    = 1'b0;
    pvalue    = '0;
    is_write  = 1'b0;
    s1_wdata  = op_a + op_b;
    unique case (s1_item_q.kind)
      tvm_pkg::KIND_LOAD: begin
        is_write = 1'b1;
        s1_wdata = s1_item_q.immediate;
      end
      tvm_pkg::KIND_ADD: begin
        is_write = 1'b1;
      end
      tvm_pkg::KIND_JNE: begin
        if (op_a != op_b) begin
          next_full = {1'b0, s1_item_q.jump_target};
        end
      end
      tvm_pkg::KIND_PRINT: begin
        pvalid = 1'b1;
        pvalue = op_a;
      end
      default: begin
        // Return and the unused codes only advance the counter.
      end
    endcase
  end

  assign s1_wr = s1_valid_q && adv && is_write;

  // Memory write port: the clearing pass owns it until done; the execute
  // stage is empty during that time.
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [WW-1:0] mem_wr_data;

  always_comb begin
    if (clr_busy_q) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_addr_q;
      mem_wr_data = '0;
    end else begin
      mem_wr_en   = s1_wr;
      mem_wr_addr = s1_waddr_q;
      mem_wr_data = s1_wdata;
    end
  end

  tvm_dmem #(
    .WORDS (MEM_WORDS),
    .AW    (AW)
  ) u_dmem (
    .clk_i       (clk_i),
    .rd_en_i     (in_accept),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .rd_data_a_o (rd_data_a),
    .rd_data_b_o (rd_data_b),
    .wr_en_i     (mem_wr_en),
    .wr_addr_i   (mem_wr_addr),
    .wr_data_i   (mem_wr_data)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    // The forwarding register is only meaningful for the instruction entering
    // now, so it follows the input transfers.
    fwd_valid_d = fwd_valid_q;
    if (in_accept) begin
      fwd_valid_d = s1_wr;
    end
    out_valid_d = out_valid_q;
    if (s1_valid_q && adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_busy_q  <= clr_busy_d;
      clr_addr_q  <= clr_addr_d;
      s1_valid_q  <= s1_valid_d;
      fwd_valid_q <= fwd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q   <= in_item_i;
      s1_addr_a_q <= rd_addr_a;
      s1_addr_b_q <= rd_addr_b;
      s1_waddr_q  <= IdxTab[in_item_i.index_a];
      fwd_addr_q  <= s1_waddr_q;
      fwd_data_q  <= s1_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  tvm_pkg::out_item_t out_item_q;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && adv) begin
      out_item_q.next_pc     <= next_full[PW-1:0];
      // A wrapped counter is still at or beyond any program size.
      out_item_q.finished    <= (next_full >= {1'b0, program_size});
      out_item_q.print_valid <= pvalid;
      out_item_q.print_value <= pvalue;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_fills_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted instruction did not reach the execute stage");

  a_clear_stage_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s1_valid_q && !out_valid_q)
    else $error("instruction in flight during the clearing pass");

  a_result_from_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result appeared without an instruction in the execute stage");

  a_print_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.print_valid |-> out_item_o.print_value == '0)
    else $error("print value not zero for a non-print instruction");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ============================================================================
// tb: self-checking bench for the tiny VM execute unit
// Drives decoded instructions, predicts every result with a behavioral copy
// of the data memory, and compares each result transfer field by field.
// ============================================================================
`timescale 1ns / 1ps

module tb;

  // Kind codes outside the defined set; the unit treats them as return.
  localparam logic [tvm_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [tvm_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  // Byte address of the program size register.
  localparam logic [tvm_pkg::APB_AW-1:0] PROG_SIZE_ADDR = {tvm_pkg::REG_PROGRAM_SIZE, 2'b00};

  // Run length guard. The slowest legal run (about 1700 instructions, each
  // waiting out a heavily stalling result side, plus the memory clearing pass
  // and the phase drains) stays far below this.
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned HOLD_CYCLES   = 150;
  localparam int unsigned SEGMENTS      = 6;
  localparam int unsigned SEGMENT_ITEMS = 275;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  tvm_pkg::in_item_t  in_item_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  tvm_pkg::out_item_t out_item_o;

  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [tvm_pkg::APB_AW-1:0] paddr = '0;
  logic [tvm_pkg::APB_DW-1:0] pwdata = '0;
  logic [tvm_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  tiny_vm_execute_unit_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Behavioral copy of the unit's state. The index fields are exactly as wide
  // as the memory is deep, so the modulo wrap of a word index is implicit.
  logic [tvm_pkg::WORD_W-1:0] data_words [tvm_pkg::DEF_MEM_WORDS];
  logic [tvm_pkg::PC_W-1:0]   prog_size = '0;

  tvm_pkg::in_item_t  pending_instrs[$];
  tvm_pkg::out_item_t expected_results[$];

  int err_count = 0;
  int results_seen = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // The stimulus process asks for a long result-side hold-off by bumping the
  // request count; the monitor serves each request and counts the cycles.
  int rx_hold_requests = 0;
  int rx_hold_served = 0;
  int rx_hold_left = 0;

  initial begin
    foreach (data_words[i]) data_words[i] = '0;
  end

  // Executes one instruction against the shadow memory and returns the result
  // the unit must produce for it. The successor counter is kept 17 bits wide:
  // next_pc carries its low half while finished compares the full value, so a
  // counter that wraps past the top always reports the end of the program.
  function automatic tvm_pkg::out_item_t execute_instr(tvm_pkg::in_item_t ins);
    tvm_pkg::out_item_t      res;
    logic [tvm_pkg::PC_W:0]  nxt;
    res = '0;
    nxt = {1'b0, ins.current_pc} + 1'b1;
    case (ins.kind)
      tvm_pkg::KIND_LOAD: data_words[ins.index_a] = ins.immediate;
      tvm_pkg::KIND_ADD:
        data_words[ins.index_a] = data_words[ins.index_b] + data_words[ins.index_c];
      tvm_pkg::KIND_JNE: begin
        if (data_words[ins.index_a] != data_words[ins.index_b])
          nxt = {1'b0, ins.jump_target};
      end
      tvm_pkg::KIND_PRINT: begin
        res.print_valid = 1'b1;
        res.print_value = data_words[ins.index_a];
      end
      default: ;  // return and the spare codes only advance the counter
    endcase
    res.next_pc  = nxt[tvm_pkg::PC_W-1:0];
    res.finished = (nxt >= {1'b0, prog_size});
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [tvm_pkg::WORD_W-1:0] got,
                                 logic [tvm_pkg::WORD_W-1:0] want);
    $display("ERROR result %0d %s: got %h, expected %h", results_seen, what, got, want);
    err_count++;
  endtask

  task automatic check_result(tvm_pkg::out_item_t got);
    tvm_pkg::out_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected transfer", got.print_value, '0);
    end else begin
      want = expected_results.pop_front();
      if (got.next_pc !== want.next_pc)
        report_mismatch("next_pc", tvm_pkg::WORD_W'(got.next_pc),
                        tvm_pkg::WORD_W'(want.next_pc));
      if (got.finished !== want.finished)
        report_mismatch("finished", tvm_pkg::WORD_W'(got.finished),
                        tvm_pkg::WORD_W'(want.finished));
      if (got.print_valid !== want.print_valid)
        report_mismatch("print_valid", tvm_pkg::WORD_W'(got.print_valid),
                        tvm_pkg::WORD_W'(want.print_valid));
      if (got.print_value !== want.print_value)
        report_mismatch("print_value", got.print_value, want.print_value);
    end
    results_seen++;
  endtask

  // Instruction driver. A transfer is predicted at the edge that completes it;
  // a stalled instruction is held unchanged, and gaps are only inserted when
  // a new instruction would otherwise be offered.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) expected_results.push_back(execute_instr(in_item_i));
      if (!in_valid_i || !in_stall_o) begin
        if (pending_instrs.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          in_item_i  <= pending_instrs.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and result-side stall generator.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_result(out_item_o);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_stall_i <= 1'b1;
      end else if (rx_hold_served != rx_hold_requests) begin
        rx_hold_served++;
        rx_hold_left = HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  // Run guard: a hang anywhere ends the run as a failure.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: FAIL");
    $finish;
  end

  task automatic apb_write(logic [tvm_pkg::APB_AW-1:0] addr,
                           logic [tvm_pkg::APB_DW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // The read data is sampled mid-way through the access cycle, well clear of
  // the edge that completes it.
  task automatic apb_read(logic [tvm_pkg::APB_AW-1:0] addr,
                          output logic [tvm_pkg::APB_DW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    data = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Program size is only changed with nothing in flight, and the shadow copy
  // follows the write. The read-back confirms the register holds the value.
  task automatic set_program_size(logic [tvm_pkg::PC_W-1:0] size);
    logic [tvm_pkg::APB_DW-1:0] rd;
    apb_write(PROG_SIZE_ADDR, tvm_pkg::APB_DW'(size));
    prog_size = size;
    apb_read(PROG_SIZE_ADDR, rd);
    if (rd !== tvm_pkg::APB_DW'(size))
      report_mismatch("program_size read-back", rd, tvm_pkg::APB_DW'(size));
  endtask

  // Waits until every queued instruction has been taken and every result has
  // come back, then lets the two-stage pipeline settle.
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_instrs.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic tvm_pkg::in_item_t make_instr(
      logic [tvm_pkg::KIND_W-1:0] kind, logic [tvm_pkg::PC_W-1:0] pc,
      logic [tvm_pkg::IDX_W-1:0] a, logic [tvm_pkg::IDX_W-1:0] b,
      logic [tvm_pkg::IDX_W-1:0] c, logic [tvm_pkg::WORD_W-1:0] imm,
      logic [tvm_pkg::PC_W-1:0] target);
    tvm_pkg::in_item_t ins;
    ins.kind        = kind;
    ins.current_pc  = pc;
    ins.index_a     = a;
    ins.index_b     = b;
    ins.index_c     = c;
    ins.immediate   = imm;
    ins.jump_target = target;
    return ins;
  endfunction

  // Most word indexes come from a small pool so that loads, sums, compares
  // and prints keep hitting the same words, often back to back; the rest
  // spread over the whole memory.
  function automatic logic [tvm_pkg::IDX_W-1:0] pick_index();
    if ($urandom_range(0, 99) < 80) return tvm_pkg::IDX_W'($urandom_range(0, 7));
    return tvm_pkg::IDX_W'($urandom_range(0, 255));
  endfunction

  // Counters cluster around the program size (so finished toggles) and near
  // the top of the range (so the successor wraps).
  function automatic logic [tvm_pkg::PC_W-1:0] pick_pc();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return tvm_pkg::PC_W'(16'hFFFF - $urandom_range(0, 2));
    if (r < 50) return tvm_pkg::PC_W'(prog_size + $urandom_range(0, 4) - 2);
    return tvm_pkg::PC_W'($urandom());
  endfunction

  function automatic tvm_pkg::in_item_t random_instr();
    logic [tvm_pkg::KIND_W-1:0] kind;
    logic [tvm_pkg::WORD_W-1:0] imm;
    int unsigned                r;
    r = $urandom_range(0, 99);
    if (r < 25)      kind = tvm_pkg::KIND_LOAD;
    else if (r < 50) kind = tvm_pkg::KIND_ADD;
    else if (r < 68) kind = tvm_pkg::KIND_JNE;
    else if (r < 83) kind = tvm_pkg::KIND_PRINT;
    else if (r < 93) kind = tvm_pkg::KIND_RET;
    else kind = tvm_pkg::KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    r = $urandom_range(0, 99);
    if (r < 70)      imm = $urandom();
    else if (r < 85) imm = tvm_pkg::WORD_W'($urandom_range(0, 3));
    else begin
      case ($urandom_range(0, 3))
        0:       imm = 32'h8000_0000;
        1:       imm = 32'h7FFF_FFFF;
        2:       imm = 32'hFFFF_FFFF;
        default: imm = '0;
      endcase
    end
    return make_instr(kind, pick_pc(), pick_index(), pick_index(), pick_index(), imm,
                      tvm_pkg::PC_W'($urandom()));
  endfunction

  initial begin
    logic [tvm_pkg::PC_W-1:0] size_val;

    // Reset, then the unit clears its memory while stalling the input side;
    // the driver simply waits on the handshake.
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, first under the reset value of program size (an empty
    // program, so every result reports finished) and with a cleared memory.
    pending_instrs.push_back(make_instr(tvm_pkg::KIND_PRINT, 16'd0, 8'd0, 8'd0, 8'd0, '0,
                                        16'd0));
    pending_instrs.push_back(make_instr(tvm_pkg::KIND_PRINT, 16'd0, 8'd255, 8'd0, 8'd0, '0,
                                        16'd0));
    pending_instrs.push_back(make_instr(tvm_pkg::KIND_RET, 16'd0, 8'd0, 8'd0, 8'd0, '0,
                                        16'd0));
    pending_instrs.push_back(make_instr(tvm_pkg::KIND_LOAD, 16'd1, 8'd255, 8'd0, 8'd0,
                                        32'h7FFF_FFFF, 16'd0));
    pending_instrs.push_back(make_instr(tvm_pkg::KIND_LOAD, 16'd2, 8'd0, 8'd0, 8'd0,
                                        32'h8000_0000, 16'd0));
    // Sums of words written by the loads just ahead, one giving exactly all
    // ones and one with a signed overflow.
    pending_instrs.push_back(make_instr(tvm_pkg::KIND_ADD, 16'd3, 8'd1, 8'd0, 8'd255, '0,
                                        16'd0));
    pending_instrs.push_back(make_instr(tvm_pkg::KIND_ADD, 16'd4, 8'd2, 8'd255, 8'd255, '0,
                                        16'd0));
    pending_instrs.push_back(make_instr(tvm_pkg::KIND_PRINT, 16'd5, 8'd1, 8'd0, 8'd0, '0,
                                        16'd0));
    wait_drained();

    set_program_size(16'hFFFF);
    // Taken jump to the very top (finished because it equals the size),
    // untaken jump on two equal words, and a compare right after a load.
    pending_instrs.push_back(make_instr(tvm_pkg::KIND_JNE, 16'd3, 8'd0, 8'd255, 8'd0, '0,
                                        16'hFFFF));
    pending_instrs.push_back(make_instr(tvm_pkg::KIND_JNE, 16'd10, 8'd3, 8'd4, 8'd0, '0,
                                        16'h1234));
    pending_instrs.push_back(make_instr(tvm_pkg::KIND_LOAD, 16'd11, 8'd3, 8'd0, 8'd0,
                                        32'hFFFF_FFFF, 16'd0));
    pending_instrs.push_back(make_instr(tvm_pkg::KIND_JNE, 16'd12, 8'd3, 8'd1, 8'd0, '0,
                                        16'h4321));
    // Counter overflow at the top of the range, and the spare kind codes.
    pending_instrs.push_back(make_instr(tvm_pkg::KIND_RET, 16'hFFFF, 8'd0, 8'd0, 8'd0, '0,
                                        16'd0));
    pending_instrs.push_back(make_instr(KIND_SPARE_LO, 16'hFFFE, 8'hFF, 8'hFF, 8'hFF,
                                        32'hFFFF_FFFF, 16'hFFFF));
    pending_instrs.push_back(make_instr(tvm_pkg::KIND_W'(KIND_SPARE_LO + 1'b1), 16'hFFFD,
                                        8'd0, 8'd0, 8'd0, '0, 16'd0));
    pending_instrs.push_back(make_instr(KIND_SPARE_HI, 16'd0, 8'd7, 8'd7, 8'd7, '0, 16'd0));
    pending_instrs.push_back(make_instr(tvm_pkg::KIND_PRINT, 16'hFFFF, 8'd2, 8'd0, 8'd0, '0,
                                        16'd0));
    // Alternating bit patterns, then a sum whose destination is also an addend.
    pending_instrs.push_back(make_instr(tvm_pkg::KIND_LOAD, 16'd20, 8'd128, 8'd0, 8'd0,
                                        32'h5555_5555, 16'd0));
    pending_instrs.push_back(make_instr(tvm_pkg::KIND_LOAD, 16'd21, 8'd64, 8'd0, 8'd0,
                                        32'hAAAA_AAAA, 16'd0));
    pending_instrs.push_back(make_instr(tvm_pkg::KIND_ADD, 16'd22, 8'd128, 8'd128, 8'd64, '0,
                                        16'd0));
    pending_instrs.push_back(make_instr(tvm_pkg::KIND_PRINT, 16'd23, 8'd128, 8'd0, 8'd0, '0,
                                        16'd0));
    pending_instrs.push_back(make_instr(tvm_pkg::KIND_JNE, 16'd24, 8'd128, 8'd1, 8'd0, '0,
                                        16'd0));
    pending_instrs.push_back(make_instr(tvm_pkg::KIND_JNE, 16'd100, 8'd128, 8'd64, 8'd0, '0,
                                        16'd0));
    wait_drained();

    // Random part in segments. Each segment starts from an idle unit with a
    // new program size; the idling pattern moves from a mostly stalling result
    // side, to a mostly idle sender, to full rate on both sides.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0:       size_val = 16'd1;
        2:       size_val = 16'd0;
        3:       size_val = 16'hFFFF;
        4:       size_val = tvm_pkg::PC_W'($urandom_range(2, 300));
        default: size_val = tvm_pkg::PC_W'($urandom());
      endcase
      set_program_size(size_val);
      if (seg < 2) begin
        tx_idle_pct = 11;
        rx_idle_pct = 61;
      end else if (seg < 4) begin
        tx_idle_pct = 61;
        rx_idle_pct = 11;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      @(negedge clk_i);
      repeat (SEGMENT_ITEMS) pending_instrs.push_back(random_instr());
      // Hold the result side off for a long stretch while instructions keep
      // coming, so the pipeline fills and the input side has to stall.
      if (seg == 4) begin
        repeat (20) @(negedge clk_i);
        rx_hold_requests++;
      end
      wait_drained();
    end

    repeat (10) @(negedge clk_i);
    if (err_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
